// ----- sv/mer_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mer_pkg
// Shared widths, codes and word types of the midpoint ellipse rasterizer.
// ----------------------------------------------------------------------------
package mer_pkg;

  // coordinate width of radii and centre
  localparam int COORD_BITS = 10;
  // emitted coordinates carry two more bits and wrap
  localparam int OB   = COORD_BITS + 2;
  // walk column offset, one bit of headroom
  localparam int XB   = COORD_BITS + 1;
  // squared radius
  localparam int SQB  = 2 * COORD_BITS;
  // multiplier operand and product
  localparam int MWB  = 2 * COORD_BITS + 2;
  localparam int PWB  = 2 * MWB;
  // decision value, four times the textbook value
  localparam int DWB  = 4 * COORD_BITS + 8;

  // command queue between front and back
  localparam int QDEPTH = 2;
  localparam int QPW    = $clog2(QDEPTH);
  localparam int QCW    = QPW + 1;

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_STEP  = 1'b1;

  localparam logic REGION_ONE = 1'b0;
  localparam logic REGION_TWO = 1'b1;

  typedef enum logic [1:0] {
    OP_START,
    OP_NULL,
    OP_STEP
  } op_e;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_ONE,
    PH_TWO
  } phase_e;

  typedef enum logic [3:0] {
    SQ_DISPATCH,
    SQ_START1,
    SQ_START2,
    SQ_START3,
    SQ_START4,
    SQ_ONE1,
    SQ_ONE2,
    SQ_HAND1,
    SQ_HAND2,
    SQ_HAND3,
    SQ_HAND4,
    SQ_TWO1,
    SQ_TWO2
  } seq_e;

  typedef struct packed {
    logic                  command;
    logic [COORD_BITS-1:0] radius_x;
    logic [COORD_BITS-1:0] radius_y;
    logic [COORD_BITS-1:0] center_x;
    logic [COORD_BITS-1:0] center_y;
  } cmd_word_t;

  typedef struct packed {
    logic signed [OB-1:0] px_pos_pos;
    logic signed [OB-1:0] py_pos_pos;
    logic signed [OB-1:0] px_neg_pos;
    logic signed [OB-1:0] py_neg_pos;
    logic signed [OB-1:0] px_neg_neg;
    logic signed [OB-1:0] py_neg_neg;
    logic signed [OB-1:0] px_pos_neg;
    logic signed [OB-1:0] py_pos_neg;
    logic                 region;
    logic                 last;
  } pix_word_t;

  // classified job as held in the queue
  typedef struct packed {
    op_e                   op;
    logic [COORD_BITS-1:0] rx;
    logic [COORD_BITS-1:0] ry;
    logic [COORD_BITS-1:0] cx;
    logic [COORD_BITS-1:0] cy;
  } job_t;

endpackage
`default_nettype wire

// ----- sv/mer_cmd_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mer_cmd_if
// Command channel: start and step words into the rasterizer.
// ----------------------------------------------------------------------------
interface mer_cmd_if import mer_pkg::*; ();
  logic      valid;
  logic      ready;
  cmd_word_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ----- sv/mer_pix_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mer_pix_if
// Pixel channel: four symmetric points per word plus region and last flags.
// ----------------------------------------------------------------------------
interface mer_pix_if import mer_pkg::*; ();
  logic      valid;
  logic      ready;
  pix_word_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ----- sv/mer_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mer_front
// Accepts command words, classifies them and holds them in a short queue.
// ----------------------------------------------------------------------------
module mer_front import mer_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  mer_cmd_if.sink    cmd_i,
  output job_t       head_o,
  output logic       head_valid_o,
  input  wire logic  pop_i
);

  job_t             mem_q [QDEPTH];
  logic [QPW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [QPW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [QCW-1:0]   cnt_q, cnt_d;
  logic             push;
  job_t             job_in;

  assign cmd_i.ready  = (cnt_q != QCW'(QDEPTH));
  assign push         = cmd_i.valid && cmd_i.ready;
  assign head_valid_o = (cnt_q != '0);
  assign head_o       = mem_q[rd_ptr_q];

  always_comb begin
    job_in.rx = cmd_i.payload.radius_x;
    job_in.ry = cmd_i.payload.radius_y;
    job_in.cx = cmd_i.payload.center_x;
    job_in.cy = cmd_i.payload.center_y;
    if (cmd_i.payload.command == CMD_STEP) begin
      job_in.op = OP_STEP;
    end else if ((cmd_i.payload.radius_x == '0) || (cmd_i.payload.radius_y == '0)) begin
      // zero radius: no walk, just drop back to idle
      job_in.op = OP_NULL;
    end else begin
      job_in.op = OP_START;
    end
  end

  always_comb begin
    wr_ptr_d = push  ? wr_ptr_q + QPW'(1) : wr_ptr_q;
    rd_ptr_d = pop_i ? rd_ptr_q + QPW'(1) : rd_ptr_q;
    case ({push, pop_i})
      2'b10:   cnt_d = cnt_q + QCW'(1);
      2'b01:   cnt_d = cnt_q - QCW'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= job_in;
    end
  end

endmodule
`default_nettype wire

// ----- sv/mer_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mer_back
// Sequencer around one shared multiplier: runs start set-up and walk steps,
// and holds the output word until it is taken.
// ----------------------------------------------------------------------------
module mer_back import mer_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire job_t  head_i,
  input  wire logic  head_valid_i,
  output logic       pop_o,
  mer_pix_if.source  pix_o
);

  seq_e                     state_q, state_d;
  phase_e                   phase_q, phase_d;
  logic [XB-1:0]            x_q, x_d;
  logic [COORD_BITS-1:0]    y_q, y_d;
  logic signed [DWB-1:0]    dec_q, dec_d;
  logic [SQB-1:0]           rxsq_q, rxsq_d;
  logic [SQB-1:0]           rysq_q, rysq_d;
  logic [PWB-1:0]           rr_q, rr_d;
  logic [PWB-1:0]           prod_q;
  logic [PWB-1:0]           acc_q, acc_d;
  logic [MWB-1:0]           sq_q, sq_d;
  logic                     flag_q, flag_d;
  logic [COORD_BITS-1:0]    cx_q, cx_d;
  logic [COORD_BITS-1:0]    cy_q, cy_d;
  logic                     out_valid_q, out_valid_d;
  pix_word_t                out_word_q, out_word_d;

  logic [MWB-1:0]           mul_a, mul_b;
  logic [PWB-1:0]           prod;
  logic                     can_emit;
  logic                     emit;
  logic                     emit_region;
  logic                     emit_last;
  logic [COORD_BITS-1:0]    y_m1;

  assign prod     = mul_a * mul_b;
  assign can_emit = !out_valid_q || pix_o.ready;
  assign y_m1     = y_q - COORD_BITS'(1);

  assign pix_o.valid   = out_valid_q;
  assign pix_o.payload = out_word_q;

  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    x_d         = x_q;
    y_d         = y_q;
    dec_d       = dec_q;
    rxsq_d      = rxsq_q;
    rysq_d      = rysq_q;
    rr_d        = rr_q;
    acc_d       = acc_q;
    sq_d        = sq_q;
    flag_d      = flag_q;
    cx_d        = cx_q;
    cy_d        = cy_q;
    mul_a       = '0;
    mul_b       = '0;
    pop_o       = 1'b0;
    emit        = 1'b0;
    emit_region = REGION_ONE;
    emit_last   = 1'b0;

    case (state_q)
      SQ_DISPATCH: begin
        if (head_valid_i) begin
          case (head_i.op)
            OP_START: begin
              mul_a   = MWB'(head_i.rx);
              mul_b   = MWB'(head_i.rx);
              state_d = SQ_START1;
            end
            OP_STEP: begin
              case (phase_q)
                PH_ONE: begin
                  x_d    = x_q + XB'(1);
                  flag_d = !dec_q[DWB-1];
                  if (!dec_q[DWB-1]) begin
                    y_d = y_m1;
                  end
                  mul_a   = MWB'(rysq_q);
                  mul_b   = MWB'(x_q + XB'(1));
                  state_d = SQ_ONE1;
                end
                PH_TWO: begin
                  flag_d = dec_q[DWB-1] || (dec_q == '0);
                  y_d    = y_m1;
                  if (dec_q[DWB-1] || (dec_q == '0)) begin
                    x_d = x_q + XB'(1);
                  end
                  mul_a   = MWB'(rxsq_q);
                  mul_b   = MWB'(y_m1);
                  state_d = SQ_TWO1;
                end
                default: begin
                  // step with no walk running
                  pop_o = 1'b1;
                end
              endcase
            end
            default: begin
              phase_d = PH_IDLE;
              pop_o   = 1'b1;
            end
          endcase
        end
      end

      SQ_START1: begin
        rxsq_d  = prod_q[SQB-1:0];
        mul_a   = MWB'(head_i.ry);
        mul_b   = MWB'(head_i.ry);
        state_d = SQ_START2;
      end

      SQ_START2: begin
        rysq_d  = prod_q[SQB-1:0];
        mul_a   = MWB'(rxsq_q);
        mul_b   = MWB'(head_i.ry);
        state_d = SQ_START3;
      end

      SQ_START3: begin
        // 4 ry^2 - 4 rx^2 ry + rx^2
        dec_d   = ($signed(DWB'(rysq_q)) <<< 2) - ($signed(DWB'(prod_q)) <<< 2)
                + $signed(DWB'(rxsq_q));
        x_d     = '0;
        y_d     = head_i.ry;
        cx_d    = head_i.cx;
        cy_d    = head_i.cy;
        phase_d = PH_ONE;
        mul_a   = MWB'(rxsq_q);
        mul_b   = MWB'(rysq_q);
        state_d = SQ_START4;
      end

      SQ_START4: begin
        rr_d    = prod_q;
        pop_o   = 1'b1;
        state_d = SQ_DISPATCH;
      end

      SQ_ONE1: begin
        acc_d   = prod_q;
        mul_a   = MWB'(rxsq_q);
        mul_b   = MWB'(y_q);
        state_d = SQ_ONE2;
      end

      SQ_ONE2: begin
        // acc holds ry^2 x, prod holds rx^2 y
        // keep the product in place while the output word waits
        mul_a = MWB'(rxsq_q);
        mul_b = MWB'(y_q);
        if (can_emit) begin
          emit        = 1'b1;
          emit_region = REGION_ONE;
          dec_d       = dec_q + ($signed(DWB'(acc_q)) <<< 3)
                      + ($signed(DWB'(rysq_q)) <<< 2)
                      - (flag_q ? ($signed(DWB'(prod_q)) <<< 3) : '0);
          if (acc_q < prod_q) begin
            pop_o   = 1'b1;
            state_d = SQ_DISPATCH;
          end else if (y_q == '0) begin
            emit_last = 1'b1;
            phase_d   = PH_IDLE;
            pop_o     = 1'b1;
            state_d   = SQ_DISPATCH;
          end else begin
            // hand over: (2x+1)^2 first
            mul_a   = MWB'({x_q, 1'b1});
            mul_b   = MWB'({x_q, 1'b1});
            state_d = SQ_HAND1;
          end
        end
      end

      SQ_HAND1: begin
        sq_d    = prod_q[MWB-1:0];
        mul_a   = MWB'(y_m1);
        mul_b   = MWB'(y_m1);
        state_d = SQ_HAND2;
      end

      SQ_HAND2: begin
        sq_d    = prod_q[MWB-1:0];
        mul_a   = MWB'(rysq_q);
        mul_b   = sq_q;
        state_d = SQ_HAND3;
      end

      SQ_HAND3: begin
        acc_d   = prod_q;
        mul_a   = MWB'(rxsq_q);
        mul_b   = sq_q;
        state_d = SQ_HAND4;
      end

      SQ_HAND4: begin
        dec_d   = $signed(DWB'(acc_q)) + ($signed(DWB'(prod_q)) <<< 2)
                - ($signed(DWB'(rr_q)) <<< 2);
        phase_d = PH_TWO;
        pop_o   = 1'b1;
        state_d = SQ_DISPATCH;
      end

      SQ_TWO1: begin
        acc_d   = prod_q;
        mul_a   = MWB'(rysq_q);
        mul_b   = MWB'(x_q);
        state_d = SQ_TWO2;
      end

      SQ_TWO2: begin
        // acc holds rx^2 y, prod holds ry^2 x
        mul_a = MWB'(rysq_q);
        mul_b = MWB'(x_q);
        if (can_emit) begin
          emit        = 1'b1;
          emit_region = REGION_TWO;
          emit_last   = (y_q == '0);
          dec_d       = dec_q + ($signed(DWB'(rxsq_q)) <<< 2)
                      - ($signed(DWB'(acc_q)) <<< 3)
                      + (flag_q ? ($signed(DWB'(prod_q)) <<< 3) : '0);
          if (y_q == '0) begin
            phase_d = PH_IDLE;
          end
          pop_o   = 1'b1;
          state_d = SQ_DISPATCH;
        end
      end

      default: begin
        state_d = SQ_DISPATCH;
      end
    endcase
  end

  // output word
  always_comb begin
    out_word_d  = out_word_q;
    out_valid_d = out_valid_q;
    if (emit) begin
      out_word_d.px_pos_pos = OB'(cx_q) + OB'(x_q);
      out_word_d.py_pos_pos = OB'(cy_q) + OB'(y_q);
      out_word_d.px_neg_pos = OB'(cx_q) - OB'(x_q);
      out_word_d.py_neg_pos = OB'(cy_q) + OB'(y_q);
      out_word_d.px_neg_neg = OB'(cx_q) - OB'(x_q);
      out_word_d.py_neg_neg = OB'(cy_q) - OB'(y_q);
      out_word_d.px_pos_neg = OB'(cx_q) + OB'(x_q);
      out_word_d.py_pos_neg = OB'(cy_q) - OB'(y_q);
      out_word_d.region     = emit_region;
      out_word_d.last       = emit_last;
      out_valid_d           = 1'b1;
    end else if (pix_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SQ_DISPATCH;
      phase_q     <= PH_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q        <= x_d;
    y_q        <= y_d;
    dec_q      <= dec_d;
    rxsq_q     <= rxsq_d;
    rysq_q     <= rysq_d;
    rr_q       <= rr_d;
    prod_q     <= prod;
    acc_q      <= acc_d;
    sq_q       <= sq_d;
    flag_q     <= flag_d;
    cx_q       <= cx_d;
    cy_q       <= cy_d;
    out_word_q <= out_word_d;
  end

endmodule
`default_nettype wire

// ----- sv/midpoint_ellipse_rasterizer_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// midpoint_ellipse_rasterizer_unit
// Midpoint ellipse walk: start words set up a walk, step words emit points.
// ----------------------------------------------------------------------------
// A start word loads radii and centre and emits nothing; each following step
// word emits the four mirrored pixels of the next point, with region and last
// flags, until last is set. Steps outside a walk and starts with a zero radius
// produce no word. Words enter a two-deep queue and are then worked by a
// sequencer that shares one multiplier, one product per cycle: a start runs
// the set-up states, a step a multiply and an emit state, the hand-over step
// also the hand-over states, and an ignored word is dropped at dispatch. The
// result waits in an output register while the queue keeps taking words.
module midpoint_ellipse_rasterizer_unit import mer_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  mer_cmd_if.sink    cmd_i,
  mer_pix_if.source  pix_o
);

  job_t head;
  logic head_valid;
  logic pop;

  mer_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd_i),
    .head_o       (head),
    .head_valid_o (head_valid),
    .pop_i        (pop)
  );

  mer_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head),
    .head_valid_i (head_valid),
    .pop_o        (pop),
    .pix_o        (pix_o)
  );

endmodule
`default_nettype wire

// ----- sim/midpoint_ellipse_rasterizer_unit_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// midpoint_ellipse_rasterizer_unit_test
// Self-checking bench for the ellipse rasterizer. Start and step words go in
// with random gaps and pixel words are taken with random back-pressure. An
// in-bench midpoint walk predicts every pixel word, and each word out is
// compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module midpoint_ellipse_rasterizer_unit_test;
  import mer_pkg::*;

  localparam int ITEM_TARGET   = 1150;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = 40;
  localparam int IDLE_PERCENT  = 29;
  localparam int MAX_PRINTED   = 40;

  logic clk_i;
  logic rst_ni;

  mer_cmd_if cmd_if ();
  mer_pix_if pix_if ();

  midpoint_ellipse_rasterizer_unit u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd_if),
    .pix_o  (pix_if)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // walk state of the in-bench predictor
  phase_e walk_phase = PH_IDLE;
  longint x_off      = 0;
  longint y_off      = 0;
  longint decision   = 0;
  longint rx_sq      = 0;
  longint ry_sq      = 0;
  longint ctr_col    = 0;
  longint ctr_row    = 0;

  pix_word_t   pending_pixels[$];
  int unsigned mismatch_count = 0;
  int unsigned words_sent     = 0;
  int unsigned cycle_count    = 0;
  bit          steady         = 1'b0;

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTED) begin
      $display("mismatch at %0t: %s", $realtime, msg);
    end
  endtask

  task automatic check_field(input string name, input logic [OB-1:0] got_v,
                             input logic [OB-1:0] want_v);
    if (got_v !== want_v) begin
      report_mismatch($sformatf("%s got %03h want %03h", name, got_v, want_v));
    end
  endtask

  function automatic pix_word_t mirror_points(input logic region_f, input logic last_f);
    pix_word_t p;
    p.px_pos_pos = OB'(ctr_col + x_off);
    p.py_pos_pos = OB'(ctr_row + y_off);
    p.px_neg_pos = OB'(ctr_col - x_off);
    p.py_neg_pos = OB'(ctr_row + y_off);
    p.px_neg_neg = OB'(ctr_col - x_off);
    p.py_neg_neg = OB'(ctr_row - y_off);
    p.px_pos_neg = OB'(ctr_col + x_off);
    p.py_pos_neg = OB'(ctr_row - y_off);
    p.region     = region_f;
    p.last       = last_f;
    return p;
  endfunction

  // one accepted word through the walk; returns 1 when a pixel word follows
  function automatic bit walk_step(input cmd_word_t w, output pix_word_t p);
    longint rx, ry, a, b, t;
    bit     emits;
    emits = 1'b0;
    p     = '0;
    if (w.command == CMD_START) begin
      rx         = longint'(w.radius_x);
      ry         = longint'(w.radius_y);
      ctr_col    = longint'(w.center_x);
      ctr_row    = longint'(w.center_y);
      rx_sq      = rx * rx;
      ry_sq      = ry * ry;
      x_off      = 0;
      y_off      = ry;
      decision   = 4 * ry_sq - 4 * rx_sq * ry + rx_sq;
      walk_phase = (rx == 0 || ry == 0) ? PH_IDLE : PH_ONE;
    end else if (walk_phase == PH_ONE) begin
      emits = 1'b1;
      x_off++;
      if (decision >= 0) y_off--;
      a = 2 * ry_sq * x_off;
      b = 2 * rx_sq * y_off;
      if (decision < 0) decision += 4 * a + 4 * ry_sq;
      else decision += 4 * a - 4 * b + 4 * ry_sq;
      if (a < b) begin
        p = mirror_points(REGION_ONE, 1'b0);
      end else if (y_off <= 0) begin
        // region one already sits on the axis, walk ends here
        p          = mirror_points(REGION_ONE, 1'b1);
        walk_phase = PH_IDLE;
      end else begin
        p          = mirror_points(REGION_ONE, 1'b0);
        t          = 2 * x_off + 1;
        decision   = ry_sq * t * t + 4 * rx_sq * (y_off - 1) * (y_off - 1)
                   - 4 * rx_sq * ry_sq;
        walk_phase = PH_TWO;
      end
    end else if (walk_phase == PH_TWO) begin
      emits = 1'b1;
      y_off--;
      b = 2 * rx_sq * y_off;
      if (decision <= 0) begin
        x_off++;
        a = 2 * ry_sq * x_off;
        decision += 4 * a - 4 * b + 4 * rx_sq;
      end else begin
        decision += 4 * rx_sq - 4 * b;
      end
      if (y_off <= 0) begin
        p          = mirror_points(REGION_TWO, 1'b1);
        walk_phase = PH_IDLE;
      end else begin
        p = mirror_points(REGION_TWO, 1'b0);
      end
    end
    return emits;
  endfunction

  // predict on accepted command words, check accepted pixel words
  always @(posedge clk_i) begin
    pix_word_t got, want;
    if (rst_ni) begin
      if (cmd_if.valid === 1'b1 && cmd_if.ready === 1'b1) begin
        if (walk_step(cmd_if.payload, want)) pending_pixels.push_back(want);
      end
      if (pix_if.valid === 1'b1 && pix_if.ready === 1'b1) begin
        got = pix_if.payload;
        if (pending_pixels.size() == 0) begin
          report_mismatch("pixel word with none outstanding");
        end else begin
          want = pending_pixels.pop_front();
          check_field("px_pos_pos", got.px_pos_pos, want.px_pos_pos);
          check_field("py_pos_pos", got.py_pos_pos, want.py_pos_pos);
          check_field("px_neg_pos", got.px_neg_pos, want.px_neg_pos);
          check_field("py_neg_pos", got.py_neg_pos, want.py_neg_pos);
          check_field("px_neg_neg", got.px_neg_neg, want.px_neg_neg);
          check_field("py_neg_neg", got.py_neg_neg, want.py_neg_neg);
          check_field("px_pos_neg", got.px_pos_neg, want.px_pos_neg);
          check_field("py_pos_neg", got.py_pos_neg, want.py_pos_neg);
          check_field("region", OB'(got.region), OB'(want.region));
          check_field("last", OB'(got.last), OB'(want.last));
        end
      end
    end
  end

  always @(negedge clk_i) begin
    pix_if.ready <= steady || ($urandom_range(0, 99) >= IDLE_PERCENT);
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("tb: failure");
    $finish;
  end

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_word(input cmd_word_t w);
    if (!(w.command == CMD_STEP && walk_phase == PH_IDLE)) words_sent++;
    while (!steady && $urandom_range(0, 99) < IDLE_PERCENT) begin
      cmd_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    cmd_if.valid   <= 1'b1;
    cmd_if.payload <= w;
    @(posedge clk_i);
    while (cmd_if.ready !== 1'b1) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic start_ellipse(input int rx, input int ry, input int cx, input int cy);
    cmd_word_t w;
    w.command  = CMD_START;
    w.radius_x = COORD_BITS'(rx);
    w.radius_y = COORD_BITS'(ry);
    w.center_x = COORD_BITS'(cx);
    w.center_y = COORD_BITS'(cy);
    send_word(w);
  endtask

  task automatic step_walk(input int count);
    cmd_word_t w;
    repeat (count) begin
      // fields other than the command are don't-care on a step
      w.command  = CMD_STEP;
      w.radius_x = COORD_BITS'($urandom_range(0, 1023));
      w.radius_y = COORD_BITS'($urandom_range(0, 1023));
      w.center_x = COORD_BITS'($urandom_range(0, 1023));
      w.center_y = COORD_BITS'($urandom_range(0, 1023));
      send_word(w);
    end
  endtask

  task automatic finish_walk();
    while (walk_phase != PH_IDLE) step_walk(1);
  endtask

  task automatic drain_pixels();
    cmd_if.valid <= 1'b0;
    while (pending_pixels.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  function automatic int pick_radius();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 80) return $urandom_range(1, 16);
    if (sel < 95) return $urandom_range(17, 160);
    return $urandom_range(1, 1023);
  endfunction

  // unit circle at the origin: region one lands on the axis, columns wrap
  task automatic test_axis_circle();
    start_ellipse(1, 1, 0, 0);
    step_walk(2);
  endtask

  task automatic test_ignored_words();
    step_walk(2);
    start_ellipse(0, 5, 300, 400);
    step_walk(1);
    start_ellipse(7, 0, 600, 100);
    step_walk(1);
  endtask

  // full walk through region one, hand-over and region two
  task automatic test_small_walk();
    start_ellipse(2, 3, 512, 512);
    finish_walk();
  endtask

  // largest radii and centre, then a restart mid-walk with a tall ellipse
  task automatic test_extremes();
    start_ellipse(1023, 1023, 1023, 1023);
    step_walk(3);
    start_ellipse(1, 1023, 0, 0);
    step_walk(3);
  endtask

  task automatic test_random_walks();
    int  sel, rx, ry;
    bit  paused;
    paused = 1'b0;
    while (words_sent < ITEM_TARGET) begin
      steady = (words_sent >= 300 && words_sent < 600);
      if (!paused && words_sent >= 800) begin
        paused = 1'b1;
        drain_pixels();
      end
      sel = $urandom_range(0, 99);
      if (sel < 5) begin
        step_walk(1);
      end else if (sel < 9) begin
        if ($urandom_range(0, 1)) begin
          start_ellipse(0, $urandom_range(0, 1023), $urandom_range(0, 1023),
                        $urandom_range(0, 1023));
        end else begin
          start_ellipse($urandom_range(1, 1023), 0, $urandom_range(0, 1023),
                        $urandom_range(0, 1023));
        end
      end else begin
        rx = pick_radius();
        ry = pick_radius();
        start_ellipse(rx, ry, $urandom_range(0, 1023), $urandom_range(0, 1023));
        if (rx > 160 || ry > 160) begin
          // big ellipses are cut short to keep the run bounded
          step_walk($urandom_range(1, 60));
        end else if ($urandom_range(0, 99) < 12) begin
          step_walk($urandom_range(0, rx + ry));
        end else begin
          finish_walk();
          if ($urandom_range(0, 99) < 15) step_walk($urandom_range(1, 3));
        end
      end
    end
    steady = 1'b0;
  endtask

  initial begin
    cmd_if.valid   = 1'b0;
    cmd_if.payload = '0;
    pix_if.ready   = 1'b0;
    rst_ni         = 1'b0;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_axis_circle();
    test_ignored_words();
    test_small_walk();
    test_extremes();
    test_random_walks();

    drain_pixels();
    if (pending_pixels.size() != 0) begin
      report_mismatch($sformatf("%0d pixel words never arrived", pending_pixels.size()));
    end
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ----- files.f -----
sv/mer_pkg.sv
sv/mer_cmd_if.sv
sv/mer_pix_if.sv
sv/mer_front.sv
sv/mer_back.sv
sv/midpoint_ellipse_rasterizer_unit.sv
sim/midpoint_ellipse_rasterizer_unit_test.sv
